// ===== src/lzwd_pkg.sv =====
// Shared types and constants for the LZW code decoder.
// Used by every module of the block; no dependencies.
package lzwd_pkg;

  // Field widths
  localparam int CODE_W     = 12;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 7;
  localparam int IN_TDATA_W = 16;

  // Parameter defaults
  localparam int DICT_SIZE_DEF = 4096;
  localparam int MAX_LEN_DEF   = 64;

  // Codes below this are literal bytes
  localparam int LIT_CODES = 256;

  // Queue between front and back, and output queue
  localparam int Q_DEPTH   = 2;
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  // Input command codes
  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_END    = 1'b1;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_DECODE = 2'd0,
    OP_END    = 2'd1,
    OP_BAD    = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
  } op_item_t;

  // Dictionary entry
  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] val;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } res_t;

endpackage

// ===== src/lzwd_front.sv =====
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on lzwd_pkg.
module lzwd_front #(
  parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic                         s_cmd,
  input  logic [lzwd_pkg::CODE_W-1:0]  s_code,
  output logic                         q_valid,
  input  logic                         q_ready,
  output lzwd_pkg::op_item_t           q_data
);
  import lzwd_pkg::*;

  localparam int DW   = $clog2(DICT_SIZE + 1);
  localparam int CW   = (DW > CODE_W) ? DW : CODE_W;
  localparam int Q_AW = $clog2(Q_DEPTH);

  op_item_t           q_mem [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr;
  logic [Q_AW-1:0]    rd_ptr;
  logic [Q_CNT_W-1:0] count;
  op_item_t           cls;
  logic               push;
  logic               pop;

  // Classify: end command, code outside the dictionary, or a decode
  always_comb begin
    cls.code = s_code;
    if (s_cmd == CMD_END) begin
      cls.op = OP_END;
    end else if (CW'(s_code) >= CW'(DICT_SIZE)) begin
      cls.op = OP_BAD;
    end else begin
      cls.op = OP_DECODE;
    end
  end

  assign s_ready = (count < Q_CNT_W'(Q_DEPTH));
  assign push    = s_valid & s_ready;
  assign q_valid = (count != '0);
  assign pop     = q_valid & q_ready;
  assign q_data  = q_mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= cls;
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/lzwd_outq.sv =====
// Output queue: holds result items until the downstream side takes them.
// Depends on lzwd_pkg.
module lzwd_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  lzwd_pkg::res_t                push_data,
  output logic [lzwd_pkg::OQ_CNT_W-1:0] count,
  output logic                          m_valid,
  input  logic                          m_ready,
  output lzwd_pkg::res_t                m_data
);
  import lzwd_pkg::*;

  localparam int OQ_AW = $clog2(OQ_DEPTH);

  res_t             oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic             pop;

  assign m_valid = (count != '0);
  assign m_data  = oq_mem[rd_ptr];
  assign pop     = m_valid & m_ready;

  // Storage; the back end never pushes into a full queue
  always_ff @(posedge clk) begin
    if (push) oq_mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + OQ_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + OQ_AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + OQ_CNT_W'(1);
        2'b01:   count <= count - OQ_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/lzwd_back.sv =====
// Back end: dictionary, prefix chain walk into a byte stack, and emission.
// Depends on lzwd_pkg; feeds lzwd_outq.
module lzwd_back #(
  parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF,
  parameter int MAX_LEN   = lzwd_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  lzwd_pkg::op_item_t            q_data,
  output logic                          res_push,
  output lzwd_pkg::res_t                res_data,
  input  logic [lzwd_pkg::OQ_CNT_W-1:0] oq_count
);
  import lzwd_pkg::*;

  localparam int NFC_W     = $clog2(DICT_SIZE + 1);
  localparam int CMP_W     = (NFC_W > CODE_W) ? NFC_W : CODE_W;
  localparam int MEM_DEPTH = (DICT_SIZE < (1 << CODE_W)) ? DICT_SIZE : (1 << CODE_W);
  localparam int MA_W      = $clog2(MEM_DEPTH);
  localparam int SA_W      = $clog2(MAX_LEN);
  localparam int OS_W      = OQ_CNT_W + 1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LOOK  = 8'b0000_0010,
    ST_CHAIN = 8'b0000_0100,
    ST_WALK  = 8'b0000_1000,
    ST_TAIL  = 8'b0001_0000,
    ST_FIN   = 8'b0010_0000,
    ST_EMIT  = 8'b0100_0000,
    ST_ERR   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Decoder state
  logic [NFC_W-1:0]  nf, nf_next;
  logic [CODE_W-1:0] prev_code, prev_code_next;
  logic [LEN_W-1:0]  prev_len, prev_len_next;
  logic [BYTE_W-1:0] prev_first, prev_first_next;
  logic              prev_valid, prev_valid_next;

  // Per-item working registers
  logic [CODE_W-1:0] cur_code, cur_code_next;
  logic              is_kwk, is_kwk_next;
  logic [LEN_W-1:0]  str_len, str_len_next;
  logic [SA_W-1:0]   walk_idx, walk_idx_next;
  logic [CODE_W-1:0] walk_code, walk_code_next;
  logic [BYTE_W-1:0] first_byte, first_byte_next;
  logic [LEN_W-1:0]  emit_idx, emit_idx_next;
  logic              pend, pend_next;
  logic              pend_last, pend_last_next;

  // Dictionary memory
  entry_t            dict_mem [MEM_DEPTH];
  entry_t            dict_rd;
  logic              dict_re, dict_we;
  logic [MA_W-1:0]   dict_ra, dict_wa;
  entry_t            dict_wd;

  // Byte stack memory
  logic [BYTE_W-1:0] stk_mem [MAX_LEN];
  logic [BYTE_W-1:0] stk_rd;
  logic              stk_re, stk_we;
  logic [SA_W-1:0]   stk_ra, stk_wa;
  logic [BYTE_W-1:0] stk_wd;

  // Helpers
  logic              code_lit, code_above, code_eq;
  logic              dict_full, nf_in_mem;
  logic [LEN_W-1:0]  kw_len;
  logic [LEN_W-1:0]  step_len_m1;
  logic [SA_W-1:0]   step_idx;
  logic              prefix_lit;
  logic              oq_space;
  logic              err_push;
  logic              emit_last;

  assign code_lit    = CMP_W'(q_data.code) < CMP_W'(LIT_CODES);
  assign code_above  = CMP_W'(q_data.code) > CMP_W'(nf);
  assign code_eq     = CMP_W'(q_data.code) == CMP_W'(nf);
  assign dict_full   = nf >= NFC_W'(DICT_SIZE);
  assign nf_in_mem   = nf < NFC_W'(MEM_DEPTH);
  assign kw_len      = prev_len + LEN_W'(1);
  assign step_len_m1 = dict_rd.len - LEN_W'(1);
  assign step_idx    = (state == ST_LOOK) ? step_len_m1[SA_W-1:0] : walk_idx;
  assign prefix_lit  = CMP_W'(dict_rd.prefix) < CMP_W'(LIT_CODES);
  assign oq_space    = (OS_W'(oq_count) + OS_W'(pend)) < OS_W'(OQ_DEPTH);
  assign emit_last   = emit_idx == (str_len - LEN_W'(1));
  assign q_ready     = (state == ST_IDLE);

  // Result push: stack data landing, or a single error item
  assign err_push = (state == ST_ERR) && !pend && oq_space;
  assign res_push = pend | err_push;
  always_comb begin
    if (pend) begin
      res_data.data = stk_rd;
      res_data.last = pend_last;
      res_data.err  = 1'b0;
    end else begin
      res_data.data = '0;
      res_data.last = 1'b1;
      res_data.err  = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    nf_next         = nf;
    prev_code_next  = prev_code;
    prev_len_next   = prev_len;
    prev_first_next = prev_first;
    prev_valid_next = prev_valid;
    cur_code_next   = cur_code;
    is_kwk_next     = is_kwk;
    str_len_next    = str_len;
    walk_idx_next   = walk_idx;
    walk_code_next  = walk_code;
    first_byte_next = first_byte;
    emit_idx_next   = emit_idx;
    pend_next       = 1'b0;
    pend_last_next  = pend_last;
    dict_re = 1'b0;
    dict_ra = '0;
    dict_we = 1'b0;
    dict_wa = nf[MA_W-1:0];
    dict_wd = '{prefix: prev_code, val: prev_first, len: kw_len};
    stk_we  = 1'b0;
    stk_wa  = '0;
    stk_wd  = '0;
    stk_re  = 1'b0;
    stk_ra  = emit_idx[SA_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_data.op)
            OP_END: begin
              nf_next         = NFC_W'(LIT_CODES);
              prev_code_next  = '0;
              prev_valid_next = 1'b0;
            end
            OP_BAD: state_next = ST_ERR;
            OP_DECODE: begin
              cur_code_next = q_data.code;
              priority if (code_above) begin
                state_next = ST_ERR;
              end else if (code_eq) begin
                // code names the slot being created: previous string + its first byte
                if (!prev_valid || dict_full) begin
                  state_next = ST_ERR;
                end else begin
                  dict_we = nf_in_mem;
                  nf_next = nf + NFC_W'(1);
                  if (kw_len > LEN_W'(MAX_LEN)) begin
                    state_next = ST_ERR;
                  end else begin
                    stk_we         = 1'b1;
                    stk_wa         = prev_len[SA_W-1:0];
                    stk_wd         = prev_first;
                    is_kwk_next    = 1'b1;
                    str_len_next   = kw_len;
                    walk_code_next = prev_code;
                    walk_idx_next  = SA_W'(prev_len - LEN_W'(1));
                    state_next     = ST_CHAIN;
                  end
                end
              end else if (code_lit) begin
                stk_we          = 1'b1;
                stk_wa          = '0;
                stk_wd          = q_data.code[BYTE_W-1:0];
                str_len_next    = LEN_W'(1);
                first_byte_next = q_data.code[BYTE_W-1:0];
                is_kwk_next     = 1'b0;
                state_next      = ST_FIN;
              end else begin
                dict_re     = 1'b1;
                dict_ra     = q_data.code[MA_W-1:0];
                is_kwk_next = 1'b0;
                state_next  = ST_LOOK;
              end
            end
            default: state_next = ST_ERR;
          endcase
        end
      end

      ST_LOOK, ST_WALK: begin
        if ((state == ST_LOOK) && (dict_rd.len > LEN_W'(MAX_LEN))) begin
          state_next = ST_ERR;
        end else begin
          if (state == ST_LOOK) str_len_next = dict_rd.len;
          stk_we = 1'b1;
          stk_wa = step_idx;
          stk_wd = dict_rd.val;
          walk_idx_next  = step_idx - SA_W'(1);
          walk_code_next = dict_rd.prefix;
          if (prefix_lit) begin
            state_next = ST_TAIL;
          end else begin
            dict_re    = 1'b1;
            dict_ra    = dict_rd.prefix[MA_W-1:0];
            state_next = ST_WALK;
          end
        end
      end

      ST_CHAIN: begin
        if (CMP_W'(walk_code) < CMP_W'(LIT_CODES)) begin
          state_next = ST_TAIL;
        end else begin
          dict_re    = 1'b1;
          dict_ra    = walk_code[MA_W-1:0];
          state_next = ST_WALK;
        end
      end

      // Chain ends in a literal: it is the first byte of the string
      ST_TAIL: begin
        stk_we          = 1'b1;
        stk_wa          = '0;
        stk_wd          = walk_code[BYTE_W-1:0];
        first_byte_next = walk_code[BYTE_W-1:0];
        state_next      = ST_FIN;
      end

      // Add previous string + first byte, then this code becomes the previous one
      ST_FIN: begin
        if (!is_kwk && prev_valid && !dict_full) begin
          dict_we = nf_in_mem;
          dict_wd = '{prefix: prev_code, val: first_byte, len: kw_len};
          nf_next = nf + NFC_W'(1);
        end
        prev_code_next  = cur_code;
        prev_len_next   = str_len;
        prev_first_next = first_byte;
        prev_valid_next = 1'b1;
        emit_idx_next   = '0;
        state_next      = ST_EMIT;
      end

      // Read stack bytes in order as output space allows
      ST_EMIT: begin
        if (oq_space) begin
          stk_re         = 1'b1;
          pend_next      = 1'b1;
          pend_last_next = emit_last;
          emit_idx_next  = emit_idx + LEN_W'(1);
          if (emit_last) state_next = ST_IDLE;
        end
      end

      ST_ERR: begin
        if (err_push) state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Dictionary memory
  always_ff @(posedge clk) begin
    if (dict_we) dict_mem[dict_wa] <= dict_wd;
    if (dict_re) dict_rd <= dict_mem[dict_ra];
  end

  // Byte stack memory
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd <= stk_mem[stk_ra];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      nf         <= NFC_W'(LIT_CODES);
      prev_valid <= 1'b0;
      pend       <= 1'b0;
    end else begin
      state      <= state_next;
      nf         <= nf_next;
      prev_valid <= prev_valid_next;
      pend       <= pend_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prev_code  <= prev_code_next;
    prev_len   <= prev_len_next;
    prev_first <= prev_first_next;
    cur_code   <= cur_code_next;
    is_kwk     <= is_kwk_next;
    str_len    <= str_len_next;
    walk_idx   <= walk_idx_next;
    walk_code  <= walk_code_next;
    first_byte <= first_byte_next;
    emit_idx   <= emit_idx_next;
    pend_last  <= pend_last_next;
  end

endmodule

// ===== src/lzw_code_decoder.sv =====
// LZW code decoder: one dictionary code in, its string out one byte per item. An item
// passes through the front queue; the back end then walks the prefix chain of its
// string into a byte stack (one dictionary read per cycle, the single read port of the
// dictionary memory sets this) and emits the bytes at one per cycle while the output
// queue has room. Items run one at a time in the back end; the front queue holds two
// more, and results wait in a four-entry output queue. An end command resets the
// dictionary and emits nothing.
// Depends on lzwd_pkg, lzwd_front, lzwd_back, lzwd_outq.
module lzw_code_decoder #(
  parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF,
  parameter int MAX_LEN   = lzwd_pkg::MAX_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lzwd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [11:0] code
  input  logic                             s_axis_tuser,  // [0] cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lzwd_pkg::BYTE_W-1:0]      m_axis_tdata,  // [7:0] out_byte
  output logic                             m_axis_tlast,
  output logic                             m_axis_tuser   // [0] error
);
  import lzwd_pkg::*;

  logic                q_valid;
  logic                q_ready;
  op_item_t            q_data;
  logic                res_push;
  res_t                res_data;
  logic [OQ_CNT_W-1:0] oq_count;
  res_t                m_data;

  lzwd_front #(
    .DICT_SIZE(DICT_SIZE)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_cmd   (s_axis_tuser),
    .s_code  (s_axis_tdata[CODE_W-1:0]),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  lzwd_back #(
    .DICT_SIZE(DICT_SIZE),
    .MAX_LEN  (MAX_LEN)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .res_push (res_push),
    .res_data (res_data),
    .oq_count (oq_count)
  );

  lzwd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .count     (oq_count),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_data    (m_data)
  );

  assign m_axis_tdata = m_data.data;
  assign m_axis_tlast = m_data.last;
  assign m_axis_tuser = m_data.err;

endmodule

// ===== src/lzwd_checker.sv =====
// Port-level checks for the LZW code decoder, bound to the top level.
// Depends on lzwd_pkg.
module lzwd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lzwd_pkg::BYTE_W-1:0]      m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic                             m_axis_tuser
);
  import lzwd_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // An error result is a single zero byte that closes the code
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("malformed error result");

  // Reset empties the output side
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present after reset");

  // Reset leaves the input side open
  a_rst_in: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

endmodule

bind lzw_code_decoder lzwd_checker u_lzwd_checker (.*);

// ===== tb/lzw_string_board_pkg.sv =====
// Expected-byte tracker for the LZW code decoder bench: mirrors the string table
// and queues the bytes each accepted code should expand into.
// Depends on lzwd_pkg for field widths, the command codes and the result record.
`timescale 1ns / 1ps

package lzw_string_board_pkg;
  import lzwd_pkg::*;

  localparam int DICT_ENTRIES = DICT_SIZE_DEF;
  localparam int STRING_CAP   = MAX_LEN_DEF;

  class lzw_string_board;
    // Mirror of the string table
    logic [CODE_W-1:0] link [DICT_ENTRIES];
    logic [BYTE_W-1:0] tail [DICT_ENTRIES];
    int unsigned       span [DICT_ENTRIES];
    int unsigned       next_free;
    logic [CODE_W-1:0] prev_code;
    bit                prev_valid;

    res_t bytes_due [$];
    int   mismatches;

    function new();
      foreach (link[i]) begin
        link[i] = '0;
        tail[i] = '0;
        span[i] = 0;
      end
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      next_free  = LIT_CODES;
      prev_code  = '0;
      prev_valid = 1'b0;
    endfunction

    function int unsigned length_of(int unsigned c);
      if (c < LIT_CODES) return 1;
      if (c >= DICT_ENTRIES) return 0;
      return span[c];
    endfunction

    // Walk the prefix chain of a usable code, bytes in string order
    function void spell(int unsigned c, output logic [BYTE_W-1:0] s [$]);
      int unsigned n;
      int unsigned cur;
      n = length_of(c);
      if (n > STRING_CAP) n = STRING_CAP;
      cur = c;
      s = {};
      repeat (n) begin
        if (cur < LIT_CODES) begin
          s.push_front(cur[BYTE_W-1:0]);
          cur = 0;
        end else begin
          s.push_front(tail[cur]);
          cur = link[cur];
        end
      end
    endfunction

    function void grow(logic [CODE_W-1:0] pfx, logic [BYTE_W-1:0] b);
      int unsigned n;
      if (next_free >= DICT_ENTRIES) return;
      n = length_of(pfx) + 1;
      if (n > STRING_CAP) n = STRING_CAP + 1;
      link[next_free] = pfx;
      tail[next_free] = b;
      span[next_free] = n;
      next_free++;
    endfunction

    function void push_error();
      res_t r;
      r.data = '0;
      r.last = 1'b1;
      r.err  = 1'b1;
      bytes_due.push_back(r);
    endfunction

    function void push_string(logic [BYTE_W-1:0] s [$]);
      res_t r;
      foreach (s[k]) begin
        r.data = s[k];
        r.last = (k == s.size() - 1);
        r.err  = 1'b0;
        bytes_due.push_back(r);
      end
    endfunction

    // Accepted input item: update the table and queue its bytes
    function void note_code(logic cmd, logic [CODE_W-1:0] code);
      logic [BYTE_W-1:0] s [$];
      logic [BYTE_W-1:0] p [$];
      int unsigned c;
      int unsigned len;
      c = code;
      if (cmd == CMD_END) begin
        restart();
        return;
      end
      if (c >= DICT_ENTRIES || c > next_free) begin
        push_error();
        return;
      end
      if (c == next_free) begin
        // code not yet in the table: previous string plus its own first byte
        if (!prev_valid || next_free >= DICT_ENTRIES) begin
          push_error();
          return;
        end
        spell(prev_code, p);
        grow(prev_code, p[0]);
        if (length_of(c) > STRING_CAP) begin
          push_error();
          return;
        end
        spell(c, s);
        push_string(s);
      end else begin
        len = length_of(c);
        if (len > STRING_CAP || len == 0) begin
          push_error();
          return;
        end
        spell(c, s);
        push_string(s);
        if (prev_valid) grow(prev_code, s[0]);
      end
      prev_code  = code;
      prev_valid = 1'b1;
    endfunction

    task flag(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    // Accepted result item against the oldest expected byte
    task check_byte(logic [BYTE_W-1:0] data, logic last, logic err);
      res_t want;
      if (bytes_due.size() == 0) begin
        flag($sformatf("unexpected result byte=%h last=%b err=%b", data, last, err));
        return;
      end
      want = bytes_due.pop_front();
      if (data !== want.data)
        flag($sformatf("byte %h, expected %h", data, want.data));
      if (last !== want.last)
        flag($sformatf("last %b, expected %b (byte %h)", last, want.last, want.data));
      if (err !== want.err)
        flag($sformatf("error %b, expected %b (byte %h)", err, want.err, want.data));
    endtask
  endclass

endpackage

// ===== tb/lzw_code_decoder_test.sv =====
// Bench top for the LZW code decoder: drives dictionary codes and end commands with
// random gaps, checks every emitted byte against the string-table mirror.
// Depends on lzwd_pkg, lzw_string_board_pkg and the lzw_code_decoder RTL.
`timescale 1ns / 1ps

module lzw_code_decoder_test;
  import lzwd_pkg::*;
  import lzw_string_board_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 2 * MAX_LEN_DEF + 40;
  localparam int MAIN_ITEMS  = 224;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [BYTE_W-1:0]     m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  lzw_string_board board;
  int sent;

  lzw_code_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Random gap per item, with stretches of back-to-back items
  function automatic int pick_gap(int idx);
    if ((idx / 25) % 4 == 2) return 0;
    return $urandom_range(0, 7);
  endfunction

  // One input item: optional gap, then hold until accepted
  task automatic send_item(logic cmd, logic [CODE_W-1:0] code);
    int gap;
    gap = pick_gap(sent);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - CODE_W){1'b0}}, code};
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (s_axis_tready !== 1'b1) @(posedge clk);
    board.note_code(cmd, code);
    sent++;
  endtask

  // Stop offering and wait for every expected byte
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (board.bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic decode(int unsigned c);
    send_item(CMD_DECODE, CODE_W'(c));
  endtask

  // Mostly valid codes with random content, some noise and end commands
  task automatic random_item();
    int r;
    int unsigned nf;
    int unsigned reach;
    nf = board.next_free;
    r  = $urandom_range(0, 99);
    if (r < 7) begin
      send_item(CMD_END, CODE_W'($urandom));
    end else if (r < 18) begin
      send_item(CMD_DECODE, CODE_W'($urandom));
    end else if (r < 38 && board.prev_valid && nf < DICT_ENTRIES) begin
      decode(nf);
    end else if (r < 70 && nf > LIT_CODES) begin
      // recent entries give long strings
      reach = nf - LIT_CODES - 1;
      if (reach > 31) reach = 31;
      decode(nf - 1 - $urandom_range(0, reach));
    end else begin
      decode($urandom_range(0, nf - 1));
    end
  endtask

  // Chain of not-yet-known codes until an entry exceeds the string cap
  task automatic ramp_to_overlong();
    send_item(CMD_END, CODE_W'($urandom));
    decode($urandom_range(0, 255));
    repeat (STRING_CAP) decode(board.next_free);
    decode(board.next_free - 1);
    decode(board.next_free);
    decode($urandom_range(0, 255));
    send_item(CMD_END, '0);
  endtask

  // Stimulus
  initial begin : stimulus
    board         = new();
    sent          = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_DECODE;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: errors on a fresh table, literal extremes, short chains
    send_item(CMD_END, 12'hFFF);
    decode(256);
    decode(300);
    decode(4095);
    decode(0);
    decode(255);
    decode(256);
    decode(258);
    decode(257);
    decode(500);
    decode(259);
    send_item(CMD_END, 12'h000);
    decode(8'hAA);
    decode(256);
    decode(8'h55);
    decode(258);
    decode(2048);
    send_item(CMD_END, 12'h5A5);
    decode(8'h0F);

    ramp_to_overlong();

    while (sent < MAIN_ITEMS) begin
      if (sent == 150) drain();
      random_item();
    end

    send_item(CMD_END, CODE_W'($urandom));
    repeat (5) random_item();

    drain();
    repeat (SETTLE) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the block up
  initial begin : result_sink
    int gap;
    int taken;
    bit held;
    taken         = 0;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = pick_gap(taken);
      if (!held && taken == 250) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end
      @(negedge clk);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (m_axis_tvalid !== 1'b1) @(posedge clk);
      board.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      taken++;
    end
  end

  // Watchdog on cycles with no item moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
          (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== lzw_code_decoder.f =====
src/lzwd_pkg.sv
src/lzwd_front.sv
src/lzwd_outq.sv
src/lzwd_back.sv
src/lzw_code_decoder.sv
src/lzwd_checker.sv
tb/lzw_string_board_pkg.sv
tb/lzw_code_decoder_test.sv
